// ===== hw/rtl/hbe_pkg.sv =====
// Package: shared constants, payload types, state and command types of the Huffman byte encoder.
package hbe_pkg;

    localparam int SYMBOLS     = 256;
    localparam int SYM_BITS    = 8;
    localparam int NODES       = 2 * SYMBOLS - 1;
    localparam int NODE_BITS   = 9;
    localparam int COUNT_BITS  = 24;
    localparam int WEIGHT_BITS = 32;
    localparam int CODE_CAP    = 48;
    localparam int LEN_BITS    = 6;
    localparam int CTR_BITS    = 10;
    localparam int USED_BITS   = 9;
    localparam int PACK_BITS   = 8;
    localparam int PCNT_BITS   = 4;

    localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = '1;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX = '1;
    localparam logic [CTR_BITS-1:0]    INIT_LAST  = CTR_BITS'(NODES);
    localparam logic [CTR_BITS-1:0]    SCAN_LAST  = CTR_BITS'(SYMBOLS);
    localparam logic [SYM_BITS-1:0]    SYM_LAST   = SYM_BITS'(SYMBOLS - 1);
    localparam logic [NODE_BITS-1:0]   FIRST_NODE = NODE_BITS'(SYMBOLS);
    localparam logic [LEN_BITS-1:0]    LEN_CAP    = LEN_BITS'(CODE_CAP);
    localparam logic [PCNT_BITS-1:0]   PACK_FULL  = PCNT_BITS'(PACK_BITS);

    typedef enum logic [1:0] {
        FUNC_COUNT  = 2'd0,
        FUNC_BUILD  = 2'd1,
        FUNC_ENCODE = 2'd2,
        FUNC_FLUSH  = 2'd3
    } func_t;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CNT_RD,
        S_CNT_WR,
        S_INIT,
        S_LOOP,
        S_SCAN,
        S_MRG_A,
        S_MRG_B,
        S_WALK_START,
        S_WALK_RD,
        S_WALK_CHK,
        S_CODE_WR,
        S_ENC_RD,
        S_ENC_BIT,
        S_FLUSH
    } state_t;

    typedef struct packed {
        logic load;
        logic cnt_wr;
        logic init_step;
        logic scan_step;
        logic mrg_a;
        logic mrg_b;
        logic walk_start;
        logic walk_step;
        logic code_wr;
        logic enc_bit;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic init_done;
        logic scan_done;
        logic more;
        logic par_valid;
        logic last_sym;
        logic enc_done;
        logic out_free;
    } status_t;

    typedef struct packed {
        logic [NODE_BITS-1:0]   node;
        logic [WEIGHT_BITS-1:0] weight;
    } slot_t;

    typedef struct packed {
        logic                 valid;
        logic                 branch;
        logic [NODE_BITS-1:0] parent;
    } par_t;

endpackage

// ===== hw/rtl/hbe_in_if.sv =====
// Interface: input channel carrying one command item per transfer.
interface hbe_in_if;
    import hbe_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/hbe_out_if.sv =====
// Interface: output channel carrying one packed byte per transfer.
interface hbe_out_if;
    import hbe_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/huffman_byte_encoder.sv =====
// Top level: byte-wise Huffman compressor built from a controller and a datapath.
//
//   channel   direction   payload                   transfer
//   in_ch     sink        func, data_byte           valid & ready
//   out_ch    source      out_byte, out_last        valid & ready
//
// A count reads, then writes the histogram entry; an encode reads the code
// table, then packs its code bits, plus any output stall; a flush waits for a
// free output register. A build runs an initialisation pass, then per merge a
// sweep over the 256 slot memory entries, then per symbol a code walk up the
// parent memory. Reset is asynchronous and active low; histogram and code table
// are marked empty by valid bits, so no clearing pass is needed.
// A stalled output register holds the encoder only when a new byte is due.
module huffman_byte_encoder (
    input logic       clk,
    input logic       rst_n,
    hbe_in_if.sink    in_ch,
    hbe_out_if.source out_ch
);
    import hbe_pkg::*;

    cmd_t    cmd;
    status_t st;

    // sequencer: owns the input handshake and steps the datapath
    hbe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_func  (in_ch.data.func),
        .st       (st),
        .in_ready (in_ch.ready),
        .cmd      (cmd)
    );

    // memories, minimum search, code walk and packer; drives the output register
    hbe_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_byte   (in_ch.data.data_byte),
        .st        (st),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_byte  (out_ch.data.out_byte),
        .out_last  (out_ch.data.out_last)
    );

endmodule

// ===== hw/rtl/hbe_ctrl.sv =====
// Controller: sequencing state machine of the Huffman byte encoder.
module hbe_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [1:0]       in_func,
    input  hbe_pkg::status_t st,
    output logic             in_ready,
    output hbe_pkg::cmd_t    cmd
);
    import hbe_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_func)
                        FUNC_COUNT:  state_next = S_CNT_RD;
                        FUNC_BUILD:  state_next = S_INIT;
                        FUNC_ENCODE: state_next = S_ENC_RD;
                        default:     state_next = S_FLUSH;
                    endcase
                end
            end
            S_CNT_RD:     state_next = S_CNT_WR;
            S_CNT_WR:     state_next = S_IDLE;
            S_INIT:       if (st.init_done) state_next = S_LOOP;
            S_LOOP:       state_next = st.more ? S_SCAN : S_WALK_START;
            S_SCAN:       if (st.scan_done) state_next = S_MRG_A;
            S_MRG_A:      state_next = S_MRG_B;
            S_MRG_B:      state_next = S_LOOP;
            S_WALK_START: state_next = S_WALK_RD;
            S_WALK_RD:    state_next = S_WALK_CHK;
            S_WALK_CHK:   state_next = st.par_valid ? S_WALK_RD : S_CODE_WR;
            S_CODE_WR:    state_next = st.last_sym ? S_IDLE : S_WALK_START;
            S_ENC_RD:     state_next = S_ENC_BIT;
            S_ENC_BIT:    if (st.enc_done) state_next = S_IDLE;
            S_FLUSH:      if (st.out_free) state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_CNT_WR:     cmd.cnt_wr     = 1'b1;
            S_INIT:       cmd.init_step  = 1'b1;
            S_SCAN:       cmd.scan_step  = 1'b1;
            S_MRG_A:      cmd.mrg_a      = 1'b1;
            S_MRG_B:      cmd.mrg_b      = 1'b1;
            S_WALK_START: cmd.walk_start = 1'b1;
            S_WALK_CHK:   cmd.walk_step  = st.par_valid;
            S_CODE_WR:    cmd.code_wr    = 1'b1;
            S_ENC_BIT:    cmd.enc_bit    = 1'b1;
            S_FLUSH:      cmd.flush      = 1'b1;
            default:      cmd            = '0;
        endcase
    end

endmodule

// ===== hw/rtl/hbe_datapath.sv =====
// Datapath: histogram, tree and code memories, minimum search, code walk and bit packer.
module hbe_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  hbe_pkg::cmd_t    cmd,
    input  logic [7:0]       in_byte,
    output hbe_pkg::status_t st,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_byte,
    output logic             out_last
);
    import hbe_pkg::*;

    // memories
    logic [COUNT_BITS-1:0] hist_mem [SYMBOLS];
    slot_t                 slot_mem [SYMBOLS];
    par_t                  par_mem  [NODES];
    logic [CODE_CAP-1:0]   code_mem [SYMBOLS];
    logic [LEN_BITS-1:0]   len_mem  [SYMBOLS];

    logic [SYMBOLS-1:0]    hist_ok_reg, hist_ok_next;
    logic [SYMBOLS-1:0]    code_ok_reg, code_ok_next;

    logic [SYM_BITS-1:0]   byte_reg;
    logic [CTR_BITS-1:0]   ctr_reg, ctr_next;
    logic [CTR_BITS-1:0]   ctr_m1;
    logic [USED_BITS-1:0]  used_reg, used_next;
    logic [NODE_BITS-1:0]  next_reg, next_next;

    logic                  a_ok_reg, a_ok_next, b_ok_reg, b_ok_next;
    logic [SYM_BITS-1:0]   a_idx_reg, a_idx_next, b_idx_reg, b_idx_next;
    logic [NODE_BITS-1:0]  a_node_reg, a_node_next, b_node_reg, b_node_next;
    logic [WEIGHT_BITS-1:0] a_w_reg, a_w_next, b_w_reg, b_w_next;

    logic [NODE_BITS-1:0]  walk_n_reg, walk_n_next;
    logic [CODE_CAP-1:0]   acc_reg, acc_next;
    logic [LEN_BITS-1:0]   depth_reg, depth_next;

    logic [LEN_BITS-1:0]   bit_idx_reg, bit_idx_next;
    logic [7:0]            pack_byte_reg, pack_byte_next;
    logic [PCNT_BITS-1:0]  pack_cnt_reg, pack_cnt_next;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            out_byte_reg, out_byte_next;
    logic                  out_last_reg, out_last_next;

    // registered read data
    logic [COUNT_BITS-1:0] hist_q;
    logic                  hist_ok_q;
    slot_t                 slot_q;
    par_t                  par_q;
    logic [CODE_CAP-1:0]   code_q;
    logic [LEN_BITS-1:0]   len_q;
    logic                  code_ok_q;

    logic [SYM_BITS-1:0]   hist_addr;
    logic [COUNT_BITS-1:0] hist_val, hist_inc;
    logic [WEIGHT_BITS-1:0] leaf_w;
    logic                  slot_we, par_we, init_load;
    logic [SYM_BITS-1:0]   slot_waddr;
    slot_t                 slot_wdata;
    logic [NODE_BITS-1:0]  par_waddr;
    par_t                  par_wdata;
    logic [WEIGHT_BITS:0]  sum_wide;
    logic [WEIGHT_BITS-1:0] sum_sat;
    logic [LEN_BITS-1:0]   len_eff, rem;
    logic                  code_bit, need_emit, take, emit, out_free, flush_go;

    assign ctr_m1    = ctr_reg - 1'b1;
    assign hist_addr = cmd.init_step ? ctr_reg[SYM_BITS-1:0] : byte_reg;
    assign hist_val  = hist_ok_q ? hist_q : '0;
    assign hist_inc  = (hist_val == COUNT_MAX) ? hist_val : hist_val + 1'b1;
    assign leaf_w    = {{(WEIGHT_BITS-COUNT_BITS){1'b0}}, hist_val};
    assign init_load = cmd.init_step && (ctr_reg != '0) && (ctr_reg <= SCAN_LAST);
    assign sum_wide  = {1'b0, a_w_reg} + {1'b0, b_w_reg};
    assign sum_sat   = sum_wide[WEIGHT_BITS] ? WEIGHT_MAX : sum_wide[WEIGHT_BITS-1:0];

    assign out_free  = !out_valid_reg || out_ready;
    assign len_eff   = code_ok_q ? len_q : '0;
    assign rem       = len_eff - bit_idx_reg;
    assign code_bit  = code_q[bit_idx_reg];
    assign need_emit = (pack_cnt_reg == PACK_FULL);
    assign take      = cmd.enc_bit && (bit_idx_reg != len_eff) && (!need_emit || out_free);
    assign flush_go  = cmd.flush && out_free;
    assign emit      = (take && need_emit) || flush_go;

    // memory write port selection
    always_comb
    begin
        slot_we    = 1'b0;
        slot_waddr = a_idx_reg;
        slot_wdata = '{node: a_node_reg, weight: '0};
        par_we     = 1'b0;
        par_waddr  = a_node_reg;
        par_wdata  = '{valid: 1'b1, branch: 1'b0, parent: next_reg};
        if (cmd.init_step)
        begin
            slot_we    = init_load;
            slot_waddr = ctr_m1[SYM_BITS-1:0];
            slot_wdata = '{node: {1'b0, ctr_m1[SYM_BITS-1:0]}, weight: leaf_w};
            par_we     = (ctr_reg < INIT_LAST);
            par_waddr  = ctr_reg[NODE_BITS-1:0];
            par_wdata  = '0;
        end
        else if (cmd.mrg_a)
        begin
            slot_we = 1'b1;
            par_we  = 1'b1;
        end
        else if (cmd.mrg_b)
        begin
            slot_we    = 1'b1;
            slot_waddr = b_idx_reg;
            slot_wdata = '{node: next_reg, weight: sum_sat};
            par_we     = 1'b1;
            par_waddr  = b_node_reg;
            par_wdata  = '{valid: 1'b1, branch: 1'b1, parent: next_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cnt_wr)
        begin
            hist_mem[byte_reg] <= hist_inc;
        end
        hist_q    <= hist_mem[hist_addr];
        hist_ok_q <= hist_ok_reg[hist_addr];
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_q <= slot_mem[ctr_reg[SYM_BITS-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (par_we)
        begin
            par_mem[par_waddr] <= par_wdata;
        end
        par_q <= par_mem[walk_n_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.code_wr)
        begin
            code_mem[ctr_reg[SYM_BITS-1:0]] <= acc_reg;
            len_mem[ctr_reg[SYM_BITS-1:0]]  <= depth_reg;
        end
        code_q    <= code_mem[byte_reg];
        len_q     <= len_mem[byte_reg];
        code_ok_q <= code_ok_reg[byte_reg];
    end

    // control and working registers
    always_comb
    begin
        hist_ok_next   = hist_ok_reg;
        code_ok_next   = code_ok_reg;
        ctr_next       = ctr_reg;
        used_next      = used_reg;
        next_next      = next_reg;
        a_ok_next      = a_ok_reg;
        b_ok_next      = b_ok_reg;
        a_idx_next     = a_idx_reg;
        b_idx_next     = b_idx_reg;
        a_node_next    = a_node_reg;
        b_node_next    = b_node_reg;
        a_w_next       = a_w_reg;
        b_w_next       = b_w_reg;
        walk_n_next    = walk_n_reg;
        acc_next       = acc_reg;
        depth_next     = depth_reg;
        bit_idx_next   = bit_idx_reg;
        pack_byte_next = pack_byte_reg;
        pack_cnt_next  = pack_cnt_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (cmd.load)
        begin
            ctr_next     = '0;
            used_next    = '0;
            next_next    = FIRST_NODE;
            bit_idx_next = '0;
        end

        if (cmd.cnt_wr)
        begin
            hist_ok_next[byte_reg] = 1'b1;
        end

        if (cmd.init_step)
        begin
            ctr_next = (ctr_reg == INIT_LAST) ? '0 : ctr_reg + 1'b1;
            if (init_load && (leaf_w != '0))
            begin
                used_next = used_reg + 1'b1;
            end
        end

        if (cmd.scan_step)
        begin
            ctr_next = (ctr_reg == SCAN_LAST) ? '0 : ctr_reg + 1'b1;
            if (ctr_reg == '0)
            begin
                a_ok_next = 1'b0;
                b_ok_next = 1'b0;
            end
            else if (slot_q.weight != '0)
            begin
                // keep the two lightest live slots, earlier slot wins a tie
                if (!a_ok_reg || (slot_q.weight < a_w_reg))
                begin
                    b_ok_next   = a_ok_reg;
                    b_idx_next  = a_idx_reg;
                    b_node_next = a_node_reg;
                    b_w_next    = a_w_reg;
                    a_ok_next   = 1'b1;
                    a_idx_next  = ctr_m1[SYM_BITS-1:0];
                    a_node_next = slot_q.node;
                    a_w_next    = slot_q.weight;
                end
                else if (!b_ok_reg || (slot_q.weight < b_w_reg))
                begin
                    b_ok_next   = 1'b1;
                    b_idx_next  = ctr_m1[SYM_BITS-1:0];
                    b_node_next = slot_q.node;
                    b_w_next    = slot_q.weight;
                end
            end
        end

        if (cmd.mrg_b)
        begin
            used_next = used_reg - 1'b1;
            next_next = next_reg + 1'b1;
        end

        if (cmd.walk_start)
        begin
            walk_n_next = {1'b0, ctr_reg[SYM_BITS-1:0]};
            acc_next    = '0;
            depth_next  = '0;
        end

        if (cmd.walk_step)
        begin
            // shift towards the root; bits beyond the cap fall off the leaf end
            acc_next    = {acc_reg[CODE_CAP-2:0], par_q.branch};
            depth_next  = (depth_reg == LEN_CAP) ? depth_reg : depth_reg + 1'b1;
            walk_n_next = par_q.parent;
        end

        if (cmd.code_wr)
        begin
            code_ok_next[ctr_reg[SYM_BITS-1:0]] = 1'b1;
            ctr_next = (ctr_reg[SYM_BITS-1:0] == SYM_LAST) ? '0 : ctr_reg + 1'b1;
        end

        if (cmd.enc_bit && (bit_idx_reg == len_eff))
        begin
            bit_idx_next = '0;
        end

        if (take)
        begin
            bit_idx_next = bit_idx_reg + 1'b1;
            if (need_emit)
            begin
                out_byte_next  = pack_byte_reg;
                out_last_next  = (rem <= LEN_BITS'(PACK_BITS));
                pack_byte_next = {7'b0, code_bit};
                pack_cnt_next  = PCNT_BITS'(1);
            end
            else
            begin
                pack_byte_next[pack_cnt_reg[2:0]] = code_bit;
                pack_cnt_next = pack_cnt_reg + 1'b1;
            end
        end

        if (flush_go)
        begin
            out_byte_next  = pack_byte_reg;
            out_last_next  = 1'b1;
            pack_byte_next = '0;
            pack_cnt_next  = '0;
            hist_ok_next   = '0;
            code_ok_next   = '0;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_ok_reg   <= '0;
            code_ok_reg   <= '0;
            ctr_reg       <= '0;
            used_reg      <= '0;
            next_reg      <= FIRST_NODE;
            a_ok_reg      <= 1'b0;
            b_ok_reg      <= 1'b0;
            bit_idx_reg   <= '0;
            pack_byte_reg <= '0;
            pack_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hist_ok_reg   <= hist_ok_next;
            code_ok_reg   <= code_ok_next;
            ctr_reg       <= ctr_next;
            used_reg      <= used_next;
            next_reg      <= next_next;
            a_ok_reg      <= a_ok_next;
            b_ok_reg      <= b_ok_next;
            bit_idx_reg   <= bit_idx_next;
            pack_byte_reg <= pack_byte_next;
            pack_cnt_reg  <= pack_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            byte_reg <= in_byte;
        end
        a_idx_reg    <= a_idx_next;
        b_idx_reg    <= b_idx_next;
        a_node_reg   <= a_node_next;
        b_node_reg   <= b_node_next;
        a_w_reg      <= a_w_next;
        b_w_reg      <= b_w_next;
        walk_n_reg   <= walk_n_next;
        acc_reg      <= acc_next;
        depth_reg    <= depth_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign st.init_done = (ctr_reg == INIT_LAST);
    assign st.scan_done = (ctr_reg == SCAN_LAST);
    assign st.more      = (used_reg > USED_BITS'(1));
    assign st.par_valid = par_q.valid;
    assign st.last_sym  = (ctr_reg[SYM_BITS-1:0] == SYM_LAST);
    assign st.enc_done  = (bit_idx_reg == len_eff);
    assign st.out_free  = out_free;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule
